// File: src/annexb_nal_splitter_unit_defines.svh
// Assertion macros for the Annex B splitter.
// Used by annexb_nal_splitter_unit; needs no other file.
`ifndef ANNEXB_NAL_SPLITTER_UNIT_DEFINES_SVH
`define ANNEXB_NAL_SPLITTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define ANXB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ANXB_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`else
`define ANXB_ASSERT(lbl, prop, msg)
`define ANXB_ASSERT_ALWAYS(lbl, cond, msg)
`endif
`endif

// File: src/anxb_pkg.sv
// Shared types, constants and the per-byte unit function of the Annex B splitter.
// Depends on nothing; anxb_parse, anxb_serial, the top module and the testbench import it.
package anxb_pkg;

   localparam int NUM_SLOTS = 6;
   localparam int UNIT_SLOTS = 4;

   localparam logic [1:0] HELD_MAX = 2'd3;
   localparam logic [1:0] HELD_SC_MIN = 2'd2;
   localparam logic [7:0] START_LAST = 8'h01;
   localparam logic [7:0] EPB_BYTE = 8'h03;
   localparam logic [4:0] TYPE_MASK = 5'h1f;
   localparam int REF_SHIFT = 5;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] out_byte;
      logic [1:0] ref_importance;
      logic [4:0] unit_type;
   } rslt_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      rslt_type [NUM_SLOTS-1:0] slot;
   } bundle_type;

   typedef struct packed {
      logic in_unit;
      logic header_seen;
      logic [1:0] zero_run;
   } ustate_type;

   typedef struct packed {
      logic fire;
      rslt_type res;
      ustate_type st;
   } step_type;

   typedef struct packed {
      logic [1:0] held_count;
      logic in_unit;
   } stat_type;

   localparam rslt_type END_RESULT = '{kind: KIND_END, out_byte: 8'd0,
                                       ref_importance: 2'd0, unit_type: 5'd0};
   localparam ustate_type START_STATE = '{in_unit: 1'b1, header_seen: 1'b0,
                                          zero_run: 2'd0};

   // One byte handed to the open unit: header, dropped emulation byte, or payload.
   function automatic step_type unit_step(input ustate_type st, input logic [7:0] b);
      step_type r;
      logic [7:0] sh;
      sh = b >> REF_SHIFT;
      r.fire = 1'b0;
      r.res = '{kind: KIND_PAYLOAD, out_byte: 8'd0, ref_importance: 2'd0, unit_type: 5'd0};
      r.st = st;
      if (st.in_unit) begin
         if (!st.header_seen) begin
            r.fire = 1'b1;
            r.res.kind = KIND_HEADER;
            r.res.ref_importance = sh[1:0];
            r.res.unit_type = b[4:0] & TYPE_MASK;
            r.st.header_seen = 1'b1;
            r.st.zero_run = 2'd0;
         end else if (st.zero_run >= 2'd2 && b == EPB_BYTE) begin
            r.st.zero_run = 2'd0;
         end else begin
            r.fire = 1'b1;
            r.res.out_byte = b;
            if (b == 8'd0) begin
               r.st.zero_run = (st.zero_run == 2'd3) ? 2'd3 : st.zero_run + 2'd1;
            end else begin
               r.st.zero_run = 2'd0;
            end
         end
      end
      return r;
   endfunction

endpackage

// File: src/anxb_req_if.sv
// Input channel of the Annex B splitter: one stream byte per word.
// Standalone; no package needed.
interface anxb_req_if;
   logic valid;
   logic ready;
   logic [7:0] in_byte;
   logic end_of_buffer;
   modport source(output valid, output in_byte, output end_of_buffer, input ready);
   modport sink(input valid, input in_byte, input end_of_buffer, output ready);
endinterface

// File: src/anxb_rsp_if.sv
// Result channel of the Annex B splitter: one header, payload byte or end marker per word.
// Standalone; kind codes are those of anxb_pkg.
interface anxb_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [1:0] ref_importance;
   logic [4:0] unit_type;
   logic last_of_run;
   modport source(output valid, output kind, output out_byte, output ref_importance,
                  output unit_type, output last_of_run, input ready);
   modport sink(input valid, input kind, input out_byte, input ref_importance,
                input unit_type, input last_of_run, output ready);
endinterface

// File: src/anxb_parse.sv
// Start-code search and unit state; builds the bundle of results for one byte.
// Depends on anxb_pkg.
module anxb_parse import anxb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_buffer,
   output bundle_type bundle,
   output stat_type   stat
);

   // Held bytes are always zeros, so only their count is stored.
   logic [1:0] held_count_ff, held_count_in;
   ustate_type ustate_ff, ustate_in;

   logic is_zero, is_sc, use_b, slot_on;
   logic [2:0] nz;
   logic [7:0] slot_byte;
   step_type step;
   ustate_type chain [0:UNIT_SLOTS];

   always_comb begin
      is_zero = (in_byte == 8'd0);
      is_sc = (in_byte == START_LAST) && (held_count_ff >= HELD_SC_MIN);
      if (is_zero) begin
         use_b = 1'b0;
         if (end_of_buffer) begin
            nz = {1'b0, held_count_ff} + 3'd1;
         end else if (held_count_ff == HELD_MAX) begin
            nz = 3'd1;
         end else begin
            nz = 3'd0;
         end
      end else if (is_sc) begin
         use_b = 1'b0;
         nz = 3'd0;
      end else begin
         use_b = 1'b1;
         nz = {1'b0, held_count_ff};
      end

      bundle.mask = '0;
      bundle.slot = '0;
      bundle.mask[0] = is_sc && ustate_ff.in_unit && ustate_ff.header_seen;
      bundle.slot[0] = END_RESULT;

      // Leading held zeros first, then the new byte when it is not held.
      chain[0] = is_sc ? START_STATE : ustate_ff;
      slot_byte = 8'd0;
      slot_on = 1'b0;
      step = '0;
      for (int k = 0; k < UNIT_SLOTS; k++) begin
         slot_byte = (3'(k) < nz) ? 8'd0 : in_byte;
         slot_on = (3'(k) < nz) || ((3'(k) == nz) && use_b);
         step = unit_step(chain[k], slot_byte);
         if (slot_on) begin
            chain[k+1] = step.st;
            bundle.mask[k+1] = step.fire;
            bundle.slot[k+1] = step.res;
         end else begin
            chain[k+1] = chain[k];
         end
      end

      bundle.mask[NUM_SLOTS-1] = end_of_buffer && chain[UNIT_SLOTS].in_unit &&
                                 chain[UNIT_SLOTS].header_seen;
      bundle.slot[NUM_SLOTS-1] = END_RESULT;

      if (end_of_buffer) begin
         held_count_in = 2'd0;
         ustate_in = '0;
      end else begin
         ustate_in = chain[UNIT_SLOTS];
         if (is_zero) begin
            held_count_in = (held_count_ff == HELD_MAX) ? HELD_MAX : held_count_ff + 2'd1;
         end else begin
            held_count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         ustate_ff <= '0;
      end else if (accept) begin
         held_count_ff <= held_count_in;
         ustate_ff <= ustate_in;
      end
   end

   assign stat.held_count = held_count_ff;
   assign stat.in_unit = ustate_ff.in_unit;

endmodule

// File: src/anxb_serial.sv
// Result register: holds one bundle and hands its results out one per cycle while rsp_ready is high.
// Depends on anxb_pkg.
module anxb_serial import anxb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle_in,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rslt_type   rsp_result,
   output logic       rsp_last,
   output logic       can_load
);

   logic [NUM_SLOTS-1:0] mask_ff, mask_in, pick;
   rslt_type [NUM_SLOTS-1:0] slot_ff, slot_in;
   logic take;

   always_comb begin
      pick = mask_ff & (~mask_ff + 1'b1);
      rsp_valid = |mask_ff;
      rsp_last = ((mask_ff & ~pick) == '0);
      take = rsp_valid && rsp_ready;
      can_load = !rsp_valid || (take && rsp_last);
      rsp_result = slot_ff[0];
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (pick[k]) begin
            rsp_result = slot_ff[k];
         end
      end
      if (load) begin
         mask_in = bundle_in.mask;
         slot_in = bundle_in.slot;
      end else begin
         mask_in = take ? (mask_ff & ~pick) : mask_ff;
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

// File: src/annexb_nal_splitter_unit.sv
// Annex B byte-stream splitter with emulation-prevention removal. Each accepted word
// is one stream byte; start codes 00 00 01 and 00 00 00 01 delimit units, bytes before
// the first start code are dropped, and every non-empty unit comes out as a header word
// (ref_importance, unit_type), its payload bytes with emulation bytes removed, and an
// end word. The flag end_of_buffer flushes held zeros as payload and closes the unit.
// Rate: a byte is taken every cycle while the result channel is ready and each byte
// yields at most one result. A byte that yields more (up to five, when held zeros are
// released) stalls the input, as the result register hands out at most one word per
// cycle; empty result sets cost nothing. The new byte is taken in the same cycle in
// which the last waiting result leaves. There is no memory and no clearing pass.
// Depends on anxb_pkg, anxb_req_if, anxb_rsp_if, anxb_parse and anxb_serial.
`include "annexb_nal_splitter_unit_defines.svh"
module annexb_nal_splitter_unit import anxb_pkg::*; (
   input logic        clock,
   input logic        reset,
   anxb_req_if.sink   req_ch,
   anxb_rsp_if.source rsp_ch
);

   logic accept;
   logic can_load;
   logic rsp_valid;
   logic rsp_last;
   rslt_type rsp_result;
   bundle_type bundle;
   stat_type stat;

   // A byte is taken whenever the result register is empty or drains this cycle.
   assign req_ch.ready = can_load;
   assign accept = req_ch.valid && can_load;

   // The parser sees the byte directly and commits its state only on accept.
   anxb_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .in_byte       (req_ch.in_byte),
      .end_of_buffer (req_ch.end_of_buffer),
      .bundle        (bundle),
      .stat          (stat)
   );

   // The serializer holds all results of one byte and sends them in order.
   anxb_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .bundle_in  (bundle),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result),
      .rsp_last   (rsp_last),
      .can_load   (can_load)
   );

   assign rsp_ch.valid = rsp_valid;
   assign rsp_ch.kind = rsp_result.kind;
   assign rsp_ch.out_byte = rsp_result.out_byte;
   assign rsp_ch.ref_importance = rsp_result.ref_importance;
   assign rsp_ch.unit_type = rsp_result.unit_type;
   assign rsp_ch.last_of_run = rsp_last;

   // A new byte enters only when no earlier result would be left behind.
   `ANXB_ASSERT(a_accept_after_drain, accept |-> (!rsp_valid || (rsp_ch.ready && rsp_last)), "byte accepted while results were pending")
   // End of buffer returns the parser to its reset state.
   `ANXB_ASSERT(a_eob_clears, (accept && req_ch.end_of_buffer) |=> (stat.held_count == 2'd0 && !stat.in_unit), "end of buffer left state behind")
   // Only payload words carry a byte value.
   `ANXB_ASSERT_ALWAYS(a_byte_only_payload, !rsp_valid || rsp_result.kind == KIND_PAYLOAD || rsp_result.out_byte == 8'd0, "non-payload word carries a byte")

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for annexb_nal_splitter_unit: Annex B stream bytes in, unit words out.
// Depends on anxb_pkg, anxb_req_if, anxb_rsp_if and the splitter RTL; nothing else.
module tb import anxb_pkg::*; ();

   // Cycles in a row with no accepted word on either channel before the run is called hung.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles allowed after the last expected word, in case anything stray comes out.
   localparam int DRAIN_CYCLES = 20;
   // Random stream bytes, split into three idling phases.
   localparam int RANDOM_BYTES = 200;

   // Directed opening: a stray byte, both start code forms, an emulation byte, an empty
   // unit, a zero pushed out of the hold-back store, and a partial start code at the end.
   localparam logic [7:0] WARMUP_BYTES [24] = '{
      8'hAA,
      8'h00, 8'h00, 8'h01, 8'h65,
      8'h00, 8'h00, 8'h03, 8'h01,
      8'h00, 8'h00, 8'h00, 8'h01,
      8'h00, 8'h00, 8'h01,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
      8'hFF, 8'h00, 8'h00
   };

   // One expected or observed word on the result channel.
   typedef struct packed {
      rslt_type res;
      logic last_of_run;
   } unit_word_type;

   // Tracks the splitter's state on accepted bytes and holds the words they must produce.
   class unit_scoreboard;
      logic [7:0] held_q [3];
      int held_count;
      bit inside_unit;
      bit header_seen;
      logic [1:0] zero_run;
      unit_word_type run_words[$];
      unit_word_type expected_words[$];
      int errors;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         held_count = 0;
         inside_unit = 1'b0;
         header_seen = 1'b0;
         zero_run = 2'd0;
      endfunction

      function void emit(kind_type k, logic [7:0] b, logic [1:0] imp, logic [4:0] ut);
         unit_word_type w;
         w.res = '{kind: k, out_byte: b, ref_importance: imp, unit_type: ut};
         w.last_of_run = 1'b0;
         run_words = {run_words, w};
      endfunction

      // A byte that belongs to the open unit: header first, then payload minus emulation bytes.
      function void feed_unit(logic [7:0] b);
         if (!inside_unit) return;
         if (!header_seen) begin
            emit(KIND_HEADER, 8'd0, b[6:5], b[4:0]);
            header_seen = 1'b1;
            zero_run = 2'd0;
         end else if (zero_run >= 2'd2 && b == EPB_BYTE) begin
            zero_run = 2'd0;
         end else begin
            emit(KIND_PAYLOAD, b, 2'd0, 5'd0);
            if (b == 8'd0) zero_run = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
            else zero_run = 2'd0;
         end
      endfunction

      function void release_held();
         for (int k = 0; k < held_count; k++) feed_unit(held_q[k]);
         held_count = 0;
      endfunction

      function void close_unit();
         if (inside_unit && header_seen) emit(KIND_END, 8'd0, 2'd0, 5'd0);
      endfunction

      function void note_byte(logic [7:0] b, logic eob);
         run_words.delete();
         if (b == 8'd0) begin
            if (held_count >= 3) begin
               feed_unit(held_q[0]);
               held_q[0] = held_q[1];
               held_q[1] = held_q[2];
               held_count = 2;
            end
            held_q[held_count] = b;
            held_count++;
         end else if (b == START_LAST && held_count >= 2) begin
            close_unit();
            inside_unit = 1'b1;
            header_seen = 1'b0;
            zero_run = 2'd0;
            held_count = 0;
         end else begin
            release_held();
            feed_unit(b);
         end
         if (eob) begin
            release_held();
            close_unit();
            clear_state();
         end
         if (run_words.size() > 0) run_words[run_words.size() - 1].last_of_run = 1'b1;
         expected_words = {expected_words, run_words};
      endfunction

      function void flag(string what, unit_word_type want, unit_word_type got);
         errors++;
         if (errors <= 10) begin
            $write("%s: expected kind=%0d byte=%02h imp=%0d utype=%0d last=%0b, ",
                   what, want.res.kind, want.res.out_byte, want.res.ref_importance,
                   want.res.unit_type, want.last_of_run);
            $display("got kind=%0d byte=%02h imp=%0d utype=%0d last=%0b",
                     got.res.kind, got.res.out_byte, got.res.ref_importance,
                     got.res.unit_type, got.last_of_run);
         end
      endfunction

      function void check_word(unit_word_type got);
         unit_word_type want;
         if (expected_words.size() == 0) begin
            flag("unexpected word", '0, got);
            return;
         end
         want = expected_words.pop_front();
         if (got.res.kind !== want.res.kind || got.res.out_byte !== want.res.out_byte ||
             got.res.ref_importance !== want.res.ref_importance ||
             got.res.unit_type !== want.res.unit_type || got.last_of_run !== want.last_of_run)
            flag("word mismatch", want, got);
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   int send_idle_pct;
   int rsp_idle_pct;
   int idle_cycles;
   unit_scoreboard units_sb;

   anxb_req_if req_ch();
   anxb_rsp_if rsp_ch();

   annexb_nal_splitter_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offers one stream byte, after a random number of idle cycles, and waits until the
   // splitter takes it. Handshake signals are sampled at the edge before any update lands,
   // so the ready seen here is the one that the accepting edge saw as well.
   task automatic send_byte(logic [7:0] b, logic eob);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.in_byte <= b;
      req_ch.end_of_buffer <= eob;
      do @(posedge clock); while (!req_ch.ready);
      units_sb.note_byte(b, eob);
   endtask

   // One buffer of stream bytes, closed with end_of_buffer. Most buffers are well formed:
   // an optional stray prefix, a few units behind 3- or 4-byte start codes, payload heavy in
   // zeros, emulation bytes and 01s, and sometimes trailing zeros that look like a start
   // code cut short. The rest is plain noise with end_of_buffer at random.
   task automatic send_stream(inout int sent);
      logic [7:0] seq[$];
      logic [7:0] v;
      int n;
      if ($urandom_range(9) < 2) begin
         n = $urandom_range(1, 8);
         repeat (n) send_byte(8'($urandom_range(255)), $urandom_range(9) == 0);
         sent += n;
         return;
      end
      repeat ($urandom_range(2)) seq = {seq, 8'($urandom_range(255))};
      repeat ($urandom_range(1, 4)) begin
         repeat ($urandom_range(2, 3) + ($urandom_range(4) == 0)) seq = {seq, 8'h00};
         seq = {seq, START_LAST};
         // Now and then leave the unit empty, so two start codes follow each other.
         if ($urandom_range(7) != 0) begin
            seq = {seq, 8'($urandom_range(255))};
            repeat ($urandom_range(8)) begin
               case ($urandom_range(9))
                  0, 1, 2, 3: v = 8'h00;
                  4:          v = EPB_BYTE;
                  5:          v = START_LAST;
                  default:    v = 8'($urandom_range(255));
               endcase
               seq = {seq, v};
            end
         end
      end
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) seq = {seq, 8'h00};
      foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
      sent += seq.size();
   endtask

   // Result side: checks every accepted word and drops ready at random for the next cycle.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            units_sb.check_word('{res: '{kind: kind_type'(rsp_ch.kind), out_byte: rsp_ch.out_byte,
                                         ref_importance: rsp_ch.ref_importance,
                                         unit_type: rsp_ch.unit_type},
                                  last_of_run: rsp_ch.last_of_run});
         rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: a run that stops moving on both channels for too long has hung.
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Stimulus: reset, the directed opening, then random buffers in three idling phases.
   // Between phases the sender holds off until every expected word has come out, which
   // also gives the splitter a fully drained start for the next phase.
   initial begin
      int sent;
      units_sb = new();
      send_idle_pct = 11;
      rsp_idle_pct = 86;
      sent = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.in_byte <= 8'h00;
      req_ch.end_of_buffer <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (WARMUP_BYTES[i]) send_byte(WARMUP_BYTES[i], i == $size(WARMUP_BYTES) - 1);

      for (int phase = 0; phase < 3; phase++) begin
         while (sent < RANDOM_BYTES * (phase + 1) / 3) send_stream(sent);
         req_ch.valid <= 1'b0;
         while (units_sb.pending() != 0) @(posedge clock);
         // Swap the idling sides for the second phase, and stop idling for the third.
         send_idle_pct = (phase == 0) ? 86 : 0;
         rsp_idle_pct = (phase == 0) ? 11 : 0;
      end

      // Everything has been taken and answered; give stray words a chance to show up.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (units_sb.errors == 0 && units_sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
